// ===== rtl/lrbg_pkg.sv =====
// shared types and constants of the rainbow breathing led generator
`default_nettype none

package lrbg_pkg;

  localparam int unsigned LedIdxW = 6;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_BRIGHT = 2'd0;
  localparam logic [1:0] CFG_MAX_BRIGHT = 2'd1;
  localparam logic [1:0] CFG_PERIOD     = 2'd2;

  localparam logic [7:0]  MIN_BRIGHT_RST = 8'd0;
  localparam logic [7:0]  MAX_BRIGHT_RST = 8'd255;
  localparam logic [15:0] PERIOD_RST     = 16'd20;

  // per-led phase offsets
  localparam logic [7:0] HUE_STEP    = 8'd51;
  localparam logic [7:0] BREATH_STEP = 8'd20;

  // hue wheel segment starts
  localparam logic [7:0] HUE_SEG1 = 8'd85;
  localparam logic [7:0] HUE_SEG2 = 8'd170;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_time;
  } req_word_t;

  typedef struct packed {
    logic [LedIdxW-1:0] led_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last;
  } led_word_t;

endpackage

`default_nettype wire

// ===== rtl/lrbg_stream_if.sv =====
// valid/ready stream interface carrying one word per handshake
`default_nettype none

interface lrbg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrbg_scale.sv =====
// bit-serial 8x8 multiplier with rounded division by 255
`default_nettype none

module lrbg_scale (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [7:0] a_i,
  input  wire logic [7:0] b_i,
  output logic            done_o,
  output logic [7:0]      q_o
);

  logic       busy_q, done_q;
  logic [2:0] cnt_q;
  logic [7:0] a_q, b_q, hi_q, lo_q;
  logic [8:0] part;
  logic [16:0] rnd, quo;

  // one multiplier bit per cycle, product shifts out into lo_q
  assign part = {1'b0, hi_q} + {1'b0, a_q & {8{b_q[0]}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      b_q  <= {1'b0, b_q[7:1]};
      hi_q <= part[8:1];
      lo_q <= {part[0], lo_q[7:1]};
    end
  end

  // (p + 127) / 255 as (y + (y >> 8) + 1) >> 8, exact below 2^16
  assign rnd    = {1'b0, hi_q, lo_q} + 17'd127;
  assign quo    = rnd + {8'd0, rnd[16:8]} + 17'd1;
  assign q_o    = quo[15:8];
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/lrbg_pixel.sv =====
// colour of one led: hue wheel, breathing brightness and gamma via a shared scaler
`default_nettype none

module lrbg_pixel
  import lrbg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [7:0] hue_i,
  input  wire logic [7:0] breath_i,
  input  wire logic [7:0] min_i,
  input  wire logic [7:0] range_i,
  output logic            done_o,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o
);

  localparam logic [2:0] STEP_BRIGHT     = 3'd0;
  localparam logic [2:0] STEP_RED_SCALE  = 3'd1;
  localparam logic [2:0] STEP_RED_GAMMA  = 3'd2;
  localparam logic [2:0] STEP_GRN_SCALE  = 3'd3;
  localparam logic [2:0] STEP_GRN_GAMMA  = 3'd4;
  localparam logic [2:0] STEP_BLU_SCALE  = 3'd5;
  localparam logic [2:0] STEP_BLU_GAMMA  = 3'd6;

  logic [2:0] step_q;
  logic       issue_q, done_q;
  logic [7:0] bright_q, v_q, red_q, green_q, blue_q;
  logic [7:0] tri_val, off, off3, wr, wg, wb, op_a, op_b;
  logic       sc_done;
  logic [7:0] sc_q;

  // triangle breathing wave, 255 - p is the bitwise inverse of p
  always_comb begin
    if (breath_i[7]) tri_val = {~breath_i[6:0], 1'b0};
    else             tri_val = {breath_i[6:0], 1'b0};
  end

  // three-segment hue wheel
  always_comb begin
    if (hue_i < HUE_SEG1)      off = hue_i;
    else if (hue_i < HUE_SEG2) off = hue_i - HUE_SEG1;
    else                       off = hue_i - HUE_SEG2;
    off3 = off + {off[6:0], 1'b0};
    if (hue_i < HUE_SEG1) begin
      wr = 8'd255 - off3; wg = off3;           wb = 8'd0;
    end else if (hue_i < HUE_SEG2) begin
      wr = 8'd0;          wg = 8'd255 - off3;  wb = off3;
    end else begin
      wr = off3;          wg = 8'd0;           wb = 8'd255 - off3;
    end
  end

  always_comb begin
    case (step_q)
      STEP_BRIGHT: begin
        op_a = tri_val;  op_b = range_i;
      end
      STEP_RED_SCALE: begin
        op_a = wr;       op_b = bright_q;
      end
      STEP_GRN_SCALE: begin
        op_a = wg;       op_b = bright_q;
      end
      STEP_BLU_SCALE: begin
        op_a = wb;       op_b = bright_q;
      end
      default: begin
        op_a = v_q;      op_b = v_q;
      end
    endcase
  end

  lrbg_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (issue_q),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (sc_done),
    .q_o     (sc_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_BRIGHT;
      issue_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      issue_q <= 1'b0;
      done_q  <= 1'b0;
      if (start_i) begin
        step_q  <= STEP_BRIGHT;
        issue_q <= 1'b1;
      end else if (sc_done) begin
        if (step_q == STEP_BLU_GAMMA) begin
          done_q <= 1'b1;
        end else begin
          step_q  <= step_q + 3'd1;
          issue_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_done) begin
      case (step_q)
        STEP_BRIGHT:    bright_q <= min_i + sc_q;
        STEP_RED_GAMMA: red_q    <= sc_q;
        STEP_GRN_GAMMA: green_q  <= sc_q;
        STEP_BLU_GAMMA: blue_q   <= sc_q;
        default:        v_q      <= sc_q;
      endcase
    end
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

// ===== rtl/led_rainbow_breathing_generator.sv =====
// Rainbow breathing LED frame generator, top level.
// Requests come in on req_i (req_type, now_time), one word per handshake;
// colours leave on led_o (led_index, red, green, blue, last), one word per LED.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i (0 min
// brightness, 1 max brightness, 2 frame period in ms); the user must write them
// only while idle, as the block itself does not enforce it. Start, stop, unused
// codes and ticks that do not render are handled in idle, which stays ready. A
// rendering tick produces NUM_LEDS words, computed one LED at a time by a single
// bit-serial 8x8 scaler: seven products per LED, each a shift-add loop over the
// eight multiplier bits.
// req_i is not ready while a frame is being worked on; the next request is
// taken as soon as the last LED has moved into the output register.
// The output register holds a word until led_o.ready; while it is stalled the
// next LED is computed and then waits.
// Reset stops the animation, clears both phases and the deadline, and loads
// the register defaults (min 0, max 255, period 20).
`default_nettype none

module led_rainbow_breathing_generator
  import lrbg_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lrbg_stream_if.sink      req_i,
  lrbg_stream_if.source    led_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned LedW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [LedW-1:0] LED_LAST = LedW'(NUM_LEDS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_PUSH = 3'b100
  } state_e;

  state_e      state_q;
  logic [7:0]  min_q, max_q;
  logic [15:0] period_q;
  logic        running_q;
  logic [7:0]  hue_ph_q, breath_ph_q;
  logic [31:0] next_q;
  logic [LedW-1:0] led_q;
  logic [7:0]  led_hue_q, led_bp_q;
  logic        pix_start_q, out_valid_q;
  led_word_t   out_q;

  req_word_t   req;
  logic        req_acc, render, slot_free;
  logic [31:0] diff;
  logic [7:0]  range, hue_nx;
  logic        pix_done;
  logic [7:0]  pix_r, pix_g, pix_b;

  assign req       = req_i.payload;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc   = req_i.valid && (state_q == S_IDLE);
  // wrap-aware deadline: reached when the difference is non-negative
  assign diff      = req.now_time - next_q;
  assign render    = req_acc && (req.req_type == REQ_TICK) && running_q && !diff[31];
  assign range     = (max_q >= min_q) ? (max_q - min_q) : 8'd0;
  assign hue_nx    = hue_ph_q + 8'd1;
  assign slot_free = !out_valid_q || led_o.ready;

  lrbg_pixel u_pixel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pix_start_q),
    .hue_i    (led_hue_q),
    .breath_i (led_bp_q),
    .min_i    (min_q),
    .range_i  (range),
    .done_o   (pix_done),
    .red_o    (pix_r),
    .green_o  (pix_g),
    .blue_o   (pix_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= MIN_BRIGHT_RST;
      max_q       <= MAX_BRIGHT_RST;
      period_q    <= PERIOD_RST;
      running_q   <= 1'b0;
      hue_ph_q    <= '0;
      breath_ph_q <= '0;
      next_q      <= '0;
      state_q     <= S_IDLE;
      led_q       <= '0;
      pix_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pix_start_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_BRIGHT: min_q    <= cfg_data_i[7:0];
          CFG_MAX_BRIGHT: max_q    <= cfg_data_i[7:0];
          CFG_PERIOD:     period_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && led_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            if (req.req_type == REQ_START) begin
              hue_ph_q    <= '0;
              breath_ph_q <= '0;
              next_q      <= req.now_time;
              running_q   <= 1'b1;
            end else if (req.req_type == REQ_STOP) begin
              running_q <= 1'b0;
            end
          end
          if (render) begin
            // the frame works from its own copies, so phases advance now
            hue_ph_q <= hue_nx;
            if (!hue_nx[0]) breath_ph_q <= breath_ph_q + 8'd1;
            next_q      <= req.now_time + {16'd0, period_q};
            led_q       <= '0;
            pix_start_q <= 1'b1;
            state_q     <= S_CALC;
          end
        end
        S_CALC: begin
          if (pix_done) state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            if (led_q == LED_LAST) begin
              state_q <= S_IDLE;
            end else begin
              led_q       <= led_q + LedW'(1);
              pix_start_q <= 1'b1;
              state_q     <= S_CALC;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // per-led hue and breathing phase, payload only
  always_ff @(posedge clk_i) begin
    if (render) begin
      led_hue_q <= hue_ph_q;
      led_bp_q  <= breath_ph_q;
    end else if ((state_q == S_PUSH) && slot_free) begin
      led_hue_q <= led_hue_q + HUE_STEP;
      led_bp_q  <= led_bp_q + BREATH_STEP;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_PUSH) && slot_free) begin
      out_q.led_index <= LedIdxW'(led_q);
      out_q.red       <= pix_r;
      out_q.green     <= pix_g;
      out_q.blue      <= pix_b;
      out_q.last      <= (led_q == LED_LAST);
    end
  end

  assign led_o.valid   = out_valid_q;
  assign led_o.payload = out_q;

endmodule

`default_nettype wire
